>>> src/mho_pkg.sv
package mho_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W  = 10;
  localparam int ELAPSED_W = 16;
  localparam int THRESH_W  = 10;
  localparam int DWELL_W   = 12;
  localparam int SECONDS_W = 23;
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;

  // Default window depth.
  localparam int WINDOW_SIZE_DEF = 5;

  // Millisecond constants. DWELL_MS_W holds a 12-bit dwell times 1000.
  localparam int MS_PER_S   = 1000;
  localparam int DWELL_MS_W = 22;

  // Exact floor(x / 1000) for any 32-bit x: (x * DIV_MULT) >> DIV_SHIFT.
  localparam int DIV_MULT_W = 29;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = 29'd274877907;
  localparam int DIV_SHIFT  = 38;
  localparam int PROD_W     = TIME_W + DIV_MULT_W;

  // Reset values of the configuration registers.
  localparam logic [THRESH_W-1:0] THRESH_RST = 10'd25;
  localparam logic [DWELL_W-1:0]  ENTER_RST  = 12'd3;
  localparam logic [DWELL_W-1:0]  LEAVE_RST  = 12'd60;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_ENTER     = 2'd1,
    CFG_LEAVE     = 2'd2
  } cfg_idx_t;

  // Median ranking sequencer.
  typedef enum logic [1:0] {
    MED_IDLE,
    MED_LOAD,
    MED_CMP
  } med_state_t;

  // Top-level transaction sequencer.
  typedef enum logic [2:0] {
    TOP_IDLE,
    TOP_MEDIAN,
    TOP_TIME,
    TOP_DECIDE,
    TOP_DIV,
    TOP_FINISH
  } top_state_t;

  // Saturating add of an elapsed time onto a millisecond counter.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [ELAPSED_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W + 1 - ELAPSED_W){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

>>> src/mho_median.sv
module mho_median #(
  parameter int WINDOW_SIZE = mho_pkg::WINDOW_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [mho_pkg::SAMPLE_W-1:0] sample,
  output logic                        done,
  output logic [mho_pkg::SAMPLE_W-1:0] median
);
  import mho_pkg::*;

  localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CNT_W = $clog2(WINDOW_SIZE + 1);

  // Ring window storage; only the filled entries are ever read.
  logic [SAMPLE_W-1:0] win_r [WINDOW_SIZE];
  logic [IDX_W-1:0]    wr_idx_r, wr_idx_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;

  // Ranking sequencer state.
  med_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]    cand_idx_r, cand_idx_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0]    lt_cnt_r, lt_cnt_nxt;
  logic [CNT_W-1:0]    le_cnt_r, le_cnt_nxt;
  logic [SAMPLE_W-1:0] cand_r, cand_nxt;
  logic [SAMPLE_W-1:0] median_r, median_nxt;
  logic                done_r, done_nxt;

  logic [IDX_W-1:0]    rd_idx;
  logic [SAMPLE_W-1:0] rd_data;
  logic [CNT_W-1:0]    rank_k;
  logic                last_cmp;

  // Single read port shared by candidate load and comparison.
  assign rd_idx  = (state_r == MED_LOAD) ? cand_idx_r : cmp_idx_r;
  assign rd_data = win_r[rd_idx];
  assign rank_k  = fill_r >> 1;
  assign last_cmp = (CNT_W'(cmp_idx_r) == (fill_r - CNT_W'(1)));

  // Window write pointer and fill level.
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_idx_nxt = (wr_idx_r == IDX_W'(WINDOW_SIZE - 1)) ? '0 : wr_idx_r + IDX_W'(1);
      if (fill_r != CNT_W'(WINDOW_SIZE)) begin
        fill_nxt = fill_r + CNT_W'(1);
      end
    end
  end

  // Rank each candidate in turn: it is the median when at most rank_k entries
  // fall below it and more than rank_k fall at or below it.
  always_comb begin
    state_nxt    = state_r;
    cand_idx_nxt = cand_idx_r;
    cmp_idx_nxt  = cmp_idx_r;
    lt_cnt_nxt   = lt_cnt_r;
    le_cnt_nxt   = le_cnt_r;
    cand_nxt     = cand_r;
    median_nxt   = median_r;
    done_nxt     = 1'b0;
    case (state_r)
      MED_IDLE: begin
        if (push) begin
          cand_idx_nxt = '0;
          state_nxt    = MED_LOAD;
        end
      end
      MED_LOAD: begin
        cand_nxt    = rd_data;
        cmp_idx_nxt = '0;
        lt_cnt_nxt  = '0;
        le_cnt_nxt  = '0;
        state_nxt   = MED_CMP;
      end
      MED_CMP: begin
        lt_cnt_nxt  = lt_cnt_r + CNT_W'(rd_data < cand_r);
        le_cnt_nxt  = le_cnt_r + CNT_W'(rd_data <= cand_r);
        cmp_idx_nxt = cmp_idx_r + IDX_W'(1);
        if (last_cmp) begin
          if ((lt_cnt_nxt <= rank_k) && (le_cnt_nxt > rank_k)) begin
            median_nxt = cand_r;
            done_nxt   = 1'b1;
            state_nxt  = MED_IDLE;
          end else begin
            cand_idx_nxt = cand_idx_r + IDX_W'(1);
            state_nxt    = MED_LOAD;
          end
        end
      end
      default: begin
        state_nxt = MED_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= MED_IDLE;
      wr_idx_r <= '0;
      fill_r   <= '0;
      done_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wr_idx_r <= wr_idx_nxt;
      fill_r   <= fill_nxt;
      done_r   <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (push) begin
      win_r[wr_idx_r] <= sample;
    end
    cand_idx_r <= cand_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    lt_cnt_r   <= lt_cnt_nxt;
    le_cnt_r   <= le_cnt_nxt;
    cand_r     <= cand_nxt;
    median_r   <= median_nxt;
  end

  assign done   = done_r;
  assign median = median_r;

endmodule

>>> src/median_hysteresis_occupancy_unit.sv
// Occupancy detector: running upper median of motion samples with dwell
// hysteresis on the occupied / vacant decision.
//
// Input channel (in_valid / in_ready): one transaction carries a motion
// sample and the milliseconds elapsed since the previous one. Output channel
// (out_valid / out_ready): one transaction per input, giving the occupancy
// flag, the median of the filled window and whole seconds in the current
// state. Configuration: cfg_we with cfg_index selects threshold, enter dwell
// or leave dwell; other indexes are ignored. Write only while idle.
//
// The median is found by ranking one candidate at a time through a
// single shared read port, each candidate compared against every filled
// entry in turn; the median handoff, timer update, dwell decision, seconds
// conversion and output load then follow in that order. in_ready is high
// only while the sequencer is idle, so a new sample is not accepted until
// the previous one has gone through every step. The output register lets
// a new input in while the previous result is stalled; the next result
// then waits until it is taken. Synchronous reset empties the window,
// clears all timers, marks the zone vacant and restores default thresholds.
module median_hysteresis_occupancy_unit #(
  parameter int WINDOW_SIZE = mho_pkg::WINDOW_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mho_pkg::SAMPLE_W-1:0]   in_motion_sample,
  input  logic [mho_pkg::ELAPSED_W-1:0]  in_elapsed_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_occupied,
  output logic [mho_pkg::SAMPLE_W-1:0]   out_median_level,
  output logic [mho_pkg::SECONDS_W-1:0]  out_state_seconds,
  input  logic                           cfg_we,
  input  logic [mho_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mho_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mho_pkg::*;

  // Configuration registers.
  logic [THRESH_W-1:0] thresh_r;
  logic [DWELL_W-1:0]  enter_r;
  logic [DWELL_W-1:0]  leave_r;

  // Sequencer and datapath registers.
  top_state_t          state_r, state_nxt;
  logic                occ_r, occ_nxt;
  logic [TIME_W-1:0]   state_ms_r, state_ms_nxt;
  logic [TIME_W-1:0]   enter_acc_r, enter_acc_nxt;
  logic [TIME_W-1:0]   leave_acc_r, leave_acc_nxt;
  logic [ELAPSED_W-1:0] dt_r, dt_nxt;
  logic [DWELL_MS_W-1:0] dwell_ms_r, dwell_ms_nxt;
  logic                qual_r, qual_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_occ_r, out_occ_nxt;
  logic [SAMPLE_W-1:0] out_med_r, out_med_nxt;
  logic [SECONDS_W-1:0] out_sec_r, out_sec_nxt;

  logic                in_fire;
  logic                med_done;
  logic [SAMPLE_W-1:0] med;
  logic                qual;
  logic [TIME_W-1:0]   acc_sel;
  logic [DWELL_W-1:0]  dwell_sel;

  assign in_ready = (state_r == TOP_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Window storage and median ranking.
  mho_median #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_median (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_fire),
    .sample(in_motion_sample),
    .done  (med_done),
    .median(med)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
      enter_r  <= ENTER_RST;
      leave_r  <= LEAVE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: thresh_r <= cfg_wdata[THRESH_W-1:0];
        CFG_ENTER:     enter_r  <= cfg_wdata[DWELL_W-1:0];
        CFG_LEAVE:     leave_r  <= cfg_wdata[DWELL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A median qualifies when it argues for leaving the current state.
  assign qual      = occ_r ? (med < thresh_r) : (med > thresh_r);
  assign acc_sel   = occ_r ? leave_acc_r : enter_acc_r;
  assign dwell_sel = occ_r ? leave_r : enter_r;

  // Transaction sequencer.
  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    state_ms_nxt  = state_ms_r;
    enter_acc_nxt = enter_acc_r;
    leave_acc_nxt = leave_acc_r;
    dt_nxt        = dt_r;
    dwell_ms_nxt  = dwell_ms_r;
    qual_nxt      = qual_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    out_occ_nxt   = out_occ_r;
    out_med_nxt   = out_med_r;
    out_sec_nxt   = out_sec_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      TOP_IDLE: begin
        if (in_fire) begin
          dt_nxt    = in_elapsed_ms;
          state_nxt = TOP_MEDIAN;
        end
      end
      TOP_MEDIAN: begin
        // Timers update once the median is known.
        if (med_done) begin
          state_nxt = TOP_TIME;
        end
      end
      TOP_TIME: begin
        state_ms_nxt = sat_add(state_ms_r, dt_r);
        qual_nxt     = qual;
        dwell_ms_nxt = DWELL_MS_W'({{(DWELL_MS_W - DWELL_W){1'b0}}, dwell_sel}
                                   * DWELL_MS_W'(MS_PER_S));
        if (occ_r) begin
          leave_acc_nxt = qual ? sat_add(leave_acc_r, dt_r) : '0;
        end else begin
          enter_acc_nxt = qual ? sat_add(enter_acc_r, dt_r) : '0;
        end
        state_nxt = TOP_DECIDE;
      end
      TOP_DECIDE: begin
        // Dwell reached: change state and restart all timers.
        if (qual_r && (acc_sel >= {{(TIME_W - DWELL_MS_W){1'b0}}, dwell_ms_r})) begin
          occ_nxt       = !occ_r;
          state_ms_nxt  = '0;
          enter_acc_nxt = '0;
          leave_acc_nxt = '0;
        end
        state_nxt = TOP_DIV;
      end
      TOP_DIV: begin
        // Milliseconds to seconds by reciprocal multiplication.
        prod_nxt  = PROD_W'(state_ms_r) * PROD_W'(DIV_MULT);
        state_nxt = TOP_FINISH;
      end
      TOP_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_occ_nxt   = occ_r;
          out_med_nxt   = med;
          out_sec_nxt   = prod_r[DIV_SHIFT +: SECONDS_W];
          state_nxt     = TOP_IDLE;
        end
      end
      default: begin
        state_nxt = TOP_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TOP_IDLE;
      occ_r       <= 1'b0;
      state_ms_r  <= '0;
      enter_acc_r <= '0;
      leave_acc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      state_ms_r  <= state_ms_nxt;
      enter_acc_r <= enter_acc_nxt;
      leave_acc_r <= leave_acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    dt_r       <= dt_nxt;
    dwell_ms_r <= dwell_ms_nxt;
    qual_r     <= qual_nxt;
    prod_r     <= prod_nxt;
    out_occ_r  <= out_occ_nxt;
    out_med_r  <= out_med_nxt;
    out_sec_r  <= out_sec_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_occupied      = out_occ_r;
  assign out_median_level  = out_med_r;
  assign out_state_seconds = out_sec_r;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import mho_pkg::*;

  localparam int WIN = WINDOW_SIZE_DEF;
  localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX  = {SAMPLE_W{1'b1}};
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
  // Index past the end of the register list; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                 occupied;
    logic [SAMPLE_W-1:0]  median;
    logic [SECONDS_W-1:0] seconds;
  } occ_result_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  sample;
    logic [ELAPSED_W-1:0] ms;
    logic                 typed;
    occ_result_t          want;
  } sample_row_t;

  // Shapes of a run of motion samples relative to the threshold.
  typedef enum logic [1:0] {
    RUN_ABOVE,
    RUN_BELOW,
    RUN_LEVEL,
    RUN_NOISE
  } run_kind_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_motion_sample;
  logic [ELAPSED_W-1:0]  in_elapsed_ms;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_occupied;
  logic [SAMPLE_W-1:0]   out_median_level;
  logic [SECONDS_W-1:0]  out_state_seconds;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  median_hysteresis_occupancy_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_motion_sample  (in_motion_sample),
    .in_elapsed_ms     (in_elapsed_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_occupied      (out_occupied),
    .out_median_level  (out_median_level),
    .out_state_seconds (out_state_seconds),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // Mirror of the occupancy state, starting from its reset values.
  logic [SAMPLE_W-1:0] win_q [WIN] = '{default: '0};
  int                  wr_ptr = 0;
  int                  filled = 0;
  logic                occ_now = 1'b0;
  logic [TIME_W-1:0]   enter_acc = '0;
  logic [TIME_W-1:0]   leave_acc = '0;
  logic [TIME_W-1:0]   state_ms = '0;
  logic [THRESH_W-1:0] thr_q = THRESH_RST;
  logic [DWELL_W-1:0]  enter_q = ENTER_RST;
  logic [DWELL_W-1:0]  leave_q = LEAVE_RST;

  occ_result_t occ_expected [$];
  int          mismatch_count = 0;
  bit          idle_on = 1'b1;

  // Directed samples under the reset thresholds. The first rows have results that
  // follow directly from reset; the rest walk through the level-equals-threshold case,
  // an exact leave dwell and alternating bit patterns, and go through the predictor.
  sample_row_t directed_rows [18] = '{
    '{10'd0,    16'd0,     1'b1, '{1'b0, 10'd0,    23'd0}},
    '{10'd1023, 16'd65535, 1'b1, '{1'b1, 10'd1023, 23'd0}},
    '{10'd1023, 16'd65535, 1'b1, '{1'b1, 10'd1023, 23'd65}},
    '{10'd25,   16'd1000,  1'b0, '0},
    '{10'd25,   16'd999,   1'b0, '0},
    '{10'd25,   16'd0,     1'b0, '0},
    '{10'd0,    16'd30000, 1'b0, '0},
    '{10'd0,    16'd30000, 1'b0, '0},
    '{10'd0,    16'd30000, 1'b0, '0},
    '{10'd0,    16'd29999, 1'b0, '0},
    '{10'd0,    16'd1,     1'b0, '0},
    '{10'd682,  16'd43690, 1'b0, '0},
    '{10'd341,  16'd21845, 1'b0, '0},
    '{10'd1023, 16'd65535, 1'b0, '0},
    '{10'd1023, 16'd65535, 1'b0, '0},
    '{10'd1023, 16'd0,     1'b0, '0},
    '{10'd26,   16'd1,     1'b0, '0},
    '{10'd24,   16'd500,   1'b0, '0}
  };

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Millisecond counters stick at all ones instead of wrapping.
  function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] acc,
                                                input logic [ELAPSED_W-1:0] ms);
    logic [TIME_W:0] total;
    total = {1'b0, acc} + {{(TIME_W + 1 - ELAPSED_W){1'b0}}, ms};
    return total[TIME_W] ? {TIME_W{1'b1}} : total[TIME_W-1:0];
  endfunction

  // Advances the mirrored state by one sample and returns the expected result.
  task automatic occupancy_step(input logic [SAMPLE_W-1:0] sample,
                                input logic [ELAPSED_W-1:0] ms, output occ_result_t res);
    logic [SAMPLE_W-1:0] ranked [WIN];
    logic [SAMPLE_W-1:0] key;
    logic [TIME_W-1:0]   dwell_ms;
    int                  j;
    win_q[wr_ptr] = sample;
    wr_ptr = (wr_ptr + 1 >= WIN) ? 0 : wr_ptr + 1;
    if (filled < WIN) filled++;

    // Upper median: rank floor(n/2) of the filled entries in ascending order.
    for (int i = 0; i < filled; i++) ranked[i] = win_q[i];
    for (int i = 1; i < filled; i++) begin
      key = ranked[i];
      j = i;
      while (j > 0 && ranked[j-1] > key) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = key;
    end
    res.median = ranked[filled / 2];
    state_ms = add_sat(state_ms, ms);

    // Dwell hysteresis; a level equal to the threshold counts as contrary.
    if (occ_now) begin
      if (res.median < thr_q) begin
        leave_acc = add_sat(leave_acc, ms);
        dwell_ms = leave_q * MS_PER_S;
        if (leave_acc >= dwell_ms) begin
          occ_now = 1'b0;
          state_ms = '0;
          enter_acc = '0;
          leave_acc = '0;
        end
      end else begin
        leave_acc = '0;
      end
    end else begin
      if (res.median > thr_q) begin
        enter_acc = add_sat(enter_acc, ms);
        dwell_ms = enter_q * MS_PER_S;
        if (enter_acc >= dwell_ms) begin
          occ_now = 1'b1;
          state_ms = '0;
          enter_acc = '0;
          leave_acc = '0;
        end
      end else begin
        enter_acc = '0;
      end
    end
    res.occupied = occ_now;
    res.seconds = SECONDS_W'(state_ms / MS_PER_S);
  endtask

  // Offers one sample transaction and records its expected result on acceptance.
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample,
                             input logic [ELAPSED_W-1:0] ms,
                             input logic typed, input occ_result_t want);
    occ_result_t predicted;
    int          gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_motion_sample <= sample;
    in_elapsed_ms <= ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    occupancy_step(sample, ms, predicted);
    occ_expected.push_back(typed ? want : predicted);
  endtask

  // Drops the input valid and waits until every outstanding result has come back.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (occ_expected.size() != 0) @(posedge clk);
  endtask

  // One register write; the mirror follows at the same edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_THRESHOLD: thr_q = data[THRESH_W-1:0];
      CFG_ENTER:     enter_q = data[DWELL_W-1:0];
      CFG_LEAVE:     leave_q = data[DWELL_W-1:0];
      default: ;
    endcase
  endtask

  // Mostly short dwells so that runs cross them, with some long and raw values.
  function automatic logic [CFG_DATA_W-1:0] pick_dwell();
    int pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) return CFG_DATA_W'($urandom);
    if (pick == 1) return CFG_DATA_W'(3600);
    return CFG_DATA_W'($urandom_range(0, 10));
  endfunction

  // Reconfigures while idle, then sends runs of samples that hold the median on one
  // side of the threshold, at it, or anywhere. Long runs with long gaps reach the
  // largest dwells.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] thr_data,
                           input logic [CFG_DATA_W-1:0] enter_data,
                           input logic [CFG_DATA_W-1:0] leave_data,
                           input bit long_runs, input int n_items);
    run_kind_t            kind;
    int                   run_len;
    int                   sent;
    int                   pick;
    logic [SAMPLE_W-1:0]  sample;
    logic [ELAPSED_W-1:0] ms;
    quiesce();
    write_reg(CFG_THRESHOLD, thr_data);
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    write_reg(CFG_ENTER, enter_data);
    write_reg(CFG_LEAVE, leave_data);
    cfg_we <= 1'b0;
    idle_on = ($urandom_range(0, 3) != 0);

    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 40) ? RUN_ABOVE : (pick < 80) ? RUN_BELOW :
             (pick < 88) ? RUN_LEVEL : RUN_NOISE;
      run_len = long_runs ? $urandom_range(60, 80) : $urandom_range(1, 20);
      for (int k = 0; k < run_len && sent < n_items; k++) begin
        // Sample level; short runs are broken now and then by a stray sample.
        if (!long_runs && $urandom_range(0, 14) == 0) begin
          sample = SAMPLE_W'($urandom);
        end else begin
          case (kind)
            RUN_ABOVE: sample = (thr_q == SAMPLE_MAX) ? thr_q :
                                SAMPLE_W'($urandom_range(SAMPLE_MAX, thr_q + 1));
            RUN_BELOW: sample = (thr_q == '0) ? thr_q :
                                SAMPLE_W'($urandom_range(thr_q - 1, 0));
            RUN_LEVEL: sample = thr_q;
            default:   sample = SAMPLE_W'($urandom);
          endcase
        end

        // Elapsed time, weighted toward zero, the maximum and short gaps.
        pick = $urandom_range(0, 9);
        if (long_runs) ms = (pick < 8) ? ELAPSED_MAX : ELAPSED_W'($urandom);
        else if (pick == 0) ms = '0;
        else if (pick < 3) ms = ELAPSED_MAX;
        else if (pick < 6) ms = ELAPSED_W'($urandom);
        else ms = ELAPSED_W'($urandom_range(0, 5000));

        send_sample(sample, ms, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Result side: random backpressure and in-order comparison of every transaction.
  initial begin : result_sink
    occ_result_t want;
    int          stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 6) : 0;
      if (stall == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        do @(posedge clk); while (!out_valid);
        repeat (stall - 1) @(posedge clk);
        out_ready <= 1'b1;
      end
      do @(posedge clk); while (!(out_valid && out_ready));

      if (occ_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result: occupied=%0d median=%0d seconds=%0d",
                   out_occupied, out_median_level, out_state_seconds);
        end
      end else begin
        want = occ_expected.pop_front();
        if (out_occupied !== want.occupied || out_median_level !== want.median ||
            out_state_seconds !== want.seconds) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: expected occupied=%0d median=%0d seconds=%0d, got %0d %0d %0d",
                     want.occupied, want.median, want.seconds,
                     out_occupied, out_median_level, out_state_seconds);
          end
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_motion_sample = '0;
    in_elapsed_ms = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].sample, directed_rows[i].ms,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    // Zero threshold and dwells, largest dwells with long runs, then random values.
    run_phase(CFG_DATA_W'(0), CFG_DATA_W'(0), CFG_DATA_W'(0), 1'b0, 150);
    run_phase(CFG_DATA_W'(12'h3FF), CFG_DATA_W'(12'hFFF), CFG_DATA_W'(12'hFFF), 1'b1, 250);
    run_phase(CFG_DATA_W'(12'hE00), CFG_DATA_W'(12'hFFF), CFG_DATA_W'(12'hFFF), 1'b1, 250);
    for (int p = 0; p < 10; p++) begin
      run_phase(CFG_DATA_W'($urandom), pick_dwell(), pick_dwell(), 1'b0, 120);
    end

    quiesce();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
